// File: design/pwsf_pkg.sv
// ----------------------------------------------------------------------------
// pwsf_pkg: shared types and constants
// Widths, reset values, thresholds and controller-to-datapath command codes
// for the PID controller with a safety filter.
// ----------------------------------------------------------------------------
package pwsf_pkg;

   // Field and internal widths
   localparam int DATA_W   = 32;   // gains, period, setpoint, measurement
   localparam int ERR_W    = 33;   // error, Q17.16
   localparam int DERR_W   = 34;   // error difference
   localparam int OPND_W   = 34;   // multiplier operand
   localparam int PROD_W   = 2 * OPND_W;
   localparam int INTEG_W  = 48;   // integral, Q16.32
   localparam int ISUM_W   = 50;   // integral plus increment before saturation
   localparam int DERIV_W  = 50;   // derivative, Q.16
   localparam int SPLIT_W  = 24;   // low half of a split operand
   localparam int LONG_W   = 84;   // recombined split product
   localparam int CAND_W   = 60;   // PID candidate, Q.16
   localparam int SENS_W   = 16;   // current and temperature, Q8.8
   localparam int DRIVE_W  = 17;   // command, Q1.16
   localparam int CAUSE_W  = 3;
   localparam int CSR_IDX_W = 3;

   // Register reset values
   localparam logic [DATA_W-1:0] PROP_GAIN_RST  = 32'd41943;
   localparam logic [DATA_W-1:0] INTEG_GAIN_RST = 32'd301990;
   localparam logic [DATA_W-1:0] DERIV_GAIN_RST = 32'd1342;
   localparam logic [DATA_W-1:0] TIME_STEP_RST  = 32'd4294967;
   localparam logic [DATA_W-1:0] INV_STEP_RST   = 32'd65536000;

   // Safety thresholds, Q8.8
   localparam logic signed [SENS_W-1:0] TEMP_STOP     = 16'sd20480;  // 80 C
   localparam logic signed [SENS_W-1:0] TEMP_DERATE   = 16'sd17920;  // 70 C
   localparam logic signed [SENS_W-1:0] CURRENT_LIMIT = 16'sd1024;   // 4 A

   // Command limits, Q1.16
   localparam logic [DRIVE_W-1:0] LIM_STOP    = 17'd0;
   localparam logic [DRIVE_W-1:0] LIM_DERATE  = 17'd49152;
   localparam logic [DRIVE_W-1:0] LIM_CURRENT = 17'd32768;
   localparam logic [DRIVE_W-1:0] LIM_FULL    = 17'd65536;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP_GAIN  = 3'd0,
      CSR_INTEG_GAIN = 3'd1,
      CSR_DERIV_GAIN = 3'd2,
      CSR_TIME_STEP  = 3'd3,
      CSR_INV_STEP   = 3'd4
   } csr_index_type;

   typedef enum logic [CAUSE_W-1:0] {
      CAUSE_ALLOWED       = 3'd0,
      CAUSE_DEADLINE_STOP = 3'd1,
      CAUSE_THERMAL_STOP  = 3'd2,
      CAUSE_THERMAL_DERATE = 3'd3,
      CAUSE_CURRENT_CLIP  = 3'd4
   } cause_type;

   // Operand pair presented to the shared multiplier
   typedef enum logic [2:0] {
      MUL_ERR_TS   = 3'd0,
      MUL_DERR_ITS = 3'd1,
      MUL_PG_ERR   = 3'd2,
      MUL_IG_HI    = 3'd3,
      MUL_IG_LO    = 3'd4,
      MUL_DG_HI    = 3'd5,
      MUL_DG_LO    = 3'd6
   } mul_sel_type;

   // What the datapath does with the registered product
   typedef enum logic [3:0] {
      WB_NONE       = 4'd0,
      WB_INTEG      = 4'd1,
      WB_DERIV      = 4'd2,
      WB_PROP       = 4'd3,
      WB_HOLD       = 4'd4,
      WB_INTEG_TERM = 4'd5,
      WB_DERIV_TERM = 4'd6,
      WB_FILTER     = 4'd7
   } wb_sel_type;

   typedef struct packed {
      logic        load;
      mul_sel_type mul_sel;
      wb_sel_type  wb_sel;
   } dp_cmd_type;

endpackage

// File: design/pwsf_mul.sv
// ----------------------------------------------------------------------------
// pwsf_mul: shared signed multiplier
// One 34x34 signed multiply per cycle, product registered.
// ----------------------------------------------------------------------------
module pwsf_mul
   import pwsf_pkg::*;
(
   input  logic                     clock,
   input  logic signed [OPND_W-1:0] mul_a,
   input  logic signed [OPND_W-1:0] mul_b,
   output logic signed [PROD_W-1:0] product
);

   logic signed [PROD_W-1:0] product_ff;
   logic signed [PROD_W-1:0] product_in;

   assign product_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// File: design/pwsf_datapath.sv
// ----------------------------------------------------------------------------
// pwsf_datapath: PID arithmetic and safety filter
// Holds the registers, the loop state and the operand words, drives the
// shared multiplier and folds each product in as the controller commands.
// ----------------------------------------------------------------------------
module pwsf_datapath
   import pwsf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // register writes
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_wdata,
   // input word
   input  logic signed [DATA_W-1:0] req_target,
   input  logic signed [DATA_W-1:0] req_measured,
   input  logic signed [SENS_W-1:0] req_motor_current,
   input  logic signed [SENS_W-1:0] req_temperature,
   input  logic                     req_deadline_miss,
   // control
   input  dp_cmd_type               cmd,
   // result word
   output logic [DRIVE_W-1:0]       rsp_drive,
   output logic                     rsp_clipped,
   output logic [CAUSE_W-1:0]       rsp_cause
);

   // configuration
   logic signed [DATA_W-1:0] prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic [DATA_W-1:0]        time_step_ff, inv_step_ff;
   logic signed [DATA_W-1:0] prop_gain_in, integ_gain_in, deriv_gain_in;
   logic [DATA_W-1:0]        time_step_in, inv_step_in;

   // loop state
   logic signed [INTEG_W-1:0] integral_sum_ff, integral_sum_in;
   logic signed [ERR_W-1:0]   last_error_ff, last_error_in;

   // working registers for one tick
   logic signed [ERR_W-1:0]    err_ff, err_in;
   logic signed [DERR_W-1:0]   derr_ff, derr_in;
   logic signed [SENS_W-1:0]   cur_ff, cur_in;
   logic signed [SENS_W-1:0]   temp_ff, temp_in;
   logic                       miss_ff, miss_in;
   logic signed [INTEG_W-1:0]  integ_ff, integ_in;
   logic signed [DERIV_W-1:0]  deriv_ff, deriv_in;
   logic signed [PROD_W-1:0]   part_ff, part_in;
   logic signed [CAND_W-1:0]   cand_ff, cand_in;
   logic [DRIVE_W-1:0]         drive_ff, drive_in;
   logic                       clipped_ff, clipped_in;
   logic [CAUSE_W-1:0]         cause_ff, cause_in;

   logic signed [OPND_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] prod;

   logic signed [ERR_W-1:0]  err_new;
   logic signed [ISUM_W-1:0] isum_wide;
   logic signed [LONG_W-1:0] long_sum;
   logic [DRIVE_W-1:0]       lim;
   cause_type                cause_sel;
   logic                     cand_neg, cand_over;

   // ---- register writes ----
   always_comb begin
      prop_gain_in  = prop_gain_ff;
      integ_gain_in = integ_gain_ff;
      deriv_gain_in = deriv_gain_ff;
      time_step_in  = time_step_ff;
      inv_step_in   = inv_step_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PROP_GAIN:  prop_gain_in  = csr_wdata;
            CSR_INTEG_GAIN: integ_gain_in = csr_wdata;
            CSR_DERIV_GAIN: deriv_gain_in = csr_wdata;
            CSR_TIME_STEP:  time_step_in  = csr_wdata;
            CSR_INV_STEP:   inv_step_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   // ---- multiplier operands ----
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_ERR_TS: begin
            mul_a = OPND_W'(err_ff);
            mul_b = $signed({2'b00, time_step_ff});
         end
         MUL_DERR_ITS: begin
            mul_a = derr_ff;
            mul_b = $signed({2'b00, inv_step_ff});
         end
         MUL_PG_ERR: begin
            mul_a = OPND_W'(prop_gain_ff);
            mul_b = OPND_W'(err_ff);
         end
         MUL_IG_HI: begin
            mul_a = OPND_W'(integ_gain_ff);
            mul_b = OPND_W'($signed(integ_ff[INTEG_W-1:SPLIT_W]));
         end
         MUL_IG_LO: begin
            mul_a = OPND_W'(integ_gain_ff);
            mul_b = $signed({{(OPND_W-SPLIT_W){1'b0}}, integ_ff[SPLIT_W-1:0]});
         end
         MUL_DG_HI: begin
            mul_a = OPND_W'(deriv_gain_ff);
            mul_b = OPND_W'($signed(deriv_ff[DERIV_W-1:SPLIT_W]));
         end
         MUL_DG_LO: begin
            mul_a = OPND_W'(deriv_gain_ff);
            mul_b = $signed({{(OPND_W-SPLIT_W){1'b0}}, deriv_ff[SPLIT_W-1:0]});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   pwsf_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (prod)
   );

   // ---- arithmetic on the product ----
   assign err_new = ERR_W'(req_target) - ERR_W'(req_measured);

   // integral candidate; increment is floor(err*ts / 2^16)
   assign isum_wide = ISUM_W'(integral_sum_ff) + ISUM_W'($signed(prod[64:16]));

   // split product recombined: part * 2^24 + low product
   assign long_sum = (LONG_W'(part_ff) <<< SPLIT_W) + LONG_W'(prod);

   // safety priorities; both stops are a clamp to zero
   always_comb begin
      priority if (miss_ff) begin
         lim = LIM_STOP;     cause_sel = CAUSE_DEADLINE_STOP;
      end else if (temp_ff >= TEMP_STOP) begin
         lim = LIM_STOP;     cause_sel = CAUSE_THERMAL_STOP;
      end else if (temp_ff >= TEMP_DERATE) begin
         lim = LIM_DERATE;   cause_sel = CAUSE_THERMAL_DERATE;
      end else if (cur_ff >= CURRENT_LIMIT) begin
         lim = LIM_CURRENT;  cause_sel = CAUSE_CURRENT_CLIP;
      end else begin
         lim = LIM_FULL;     cause_sel = CAUSE_ALLOWED;
      end
   end

   assign cand_neg  = cand_ff[CAND_W-1];
   assign cand_over = cand_ff > $signed({{(CAND_W-DRIVE_W){1'b0}}, lim});

   always_comb begin
      err_in          = err_ff;
      derr_in         = derr_ff;
      cur_in          = cur_ff;
      temp_in         = temp_ff;
      miss_in         = miss_ff;
      integ_in        = integ_ff;
      deriv_in        = deriv_ff;
      part_in         = part_ff;
      cand_in         = cand_ff;
      drive_in        = drive_ff;
      clipped_in      = clipped_ff;
      cause_in        = cause_ff;
      integral_sum_in = integral_sum_ff;
      last_error_in   = last_error_ff;

      if (cmd.load) begin
         err_in  = err_new;
         derr_in = DERR_W'(err_new) - DERR_W'(last_error_ff);
         cur_in  = req_motor_current;
         temp_in = req_temperature;
         miss_in = req_deadline_miss;
      end

      unique case (cmd.wb_sel)
         WB_NONE: ;
         WB_INTEG: begin
            // saturate to the 48-bit range
            if (isum_wide[ISUM_W-1:INTEG_W-1] == '0 ||
                isum_wide[ISUM_W-1:INTEG_W-1] == '1) begin
               integ_in = isum_wide[INTEG_W-1:0];
            end else if (isum_wide[ISUM_W-1]) begin
               integ_in = {1'b1, {(INTEG_W-1){1'b0}}};
            end else begin
               integ_in = {1'b0, {(INTEG_W-1){1'b1}}};
            end
         end
         WB_DERIV:      deriv_in = prod[DERIV_W+15:16];
         WB_PROP:       cand_in  = CAND_W'($signed(prod[PROD_W-1:24]));
         WB_HOLD:       part_in  = prod;
         WB_INTEG_TERM: cand_in  = cand_ff + CAND_W'($signed(long_sum[LONG_W-1:40]));
         WB_DERIV_TERM: cand_in  = cand_ff + long_sum[CAND_W+23:24];
         WB_FILTER: begin
            cause_in   = cause_sel;
            clipped_in = cand_neg || cand_over;
            if (cand_neg) begin
               drive_in = '0;
            end else if (cand_over) begin
               drive_in = lim;
            end else begin
               drive_in = cand_ff[DRIVE_W-1:0];
            end
            // anti-windup: keep the integral only when the command is unclipped
            if (!(cand_neg || cand_over)) begin
               integral_sum_in = integ_ff;
            end
            last_error_in = err_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff    <= PROP_GAIN_RST;
         integ_gain_ff   <= INTEG_GAIN_RST;
         deriv_gain_ff   <= DERIV_GAIN_RST;
         time_step_ff    <= TIME_STEP_RST;
         inv_step_ff     <= INV_STEP_RST;
         integral_sum_ff <= '0;
         last_error_ff   <= '0;
      end else begin
         prop_gain_ff    <= prop_gain_in;
         integ_gain_ff   <= integ_gain_in;
         deriv_gain_ff   <= deriv_gain_in;
         time_step_ff    <= time_step_in;
         inv_step_ff     <= inv_step_in;
         integral_sum_ff <= integral_sum_in;
         last_error_ff   <= last_error_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff     <= err_in;
      derr_ff    <= derr_in;
      cur_ff     <= cur_in;
      temp_ff    <= temp_in;
      miss_ff    <= miss_in;
      integ_ff   <= integ_in;
      deriv_ff   <= deriv_in;
      part_ff    <= part_in;
      cand_ff    <= cand_in;
      drive_ff   <= drive_in;
      clipped_ff <= clipped_in;
      cause_ff   <= cause_in;
   end

   assign rsp_drive   = drive_ff;
   assign rsp_clipped = clipped_ff;
   assign rsp_cause   = cause_ff;

endmodule

// File: design/pwsf_ctrl.sv
// ----------------------------------------------------------------------------
// pwsf_ctrl: tick sequencer
// Steps the datapath through eight arithmetic steps (seven products) and the
// filter, and owns both handshakes.
// ----------------------------------------------------------------------------
module pwsf_ctrl
   import pwsf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd
);

   typedef enum logic [9:0] {
      S_IDLE = 10'b0000000001,
      S_M1   = 10'b0000000010,
      S_M2   = 10'b0000000100,
      S_M3   = 10'b0000001000,
      S_M4   = 10'b0000010000,
      S_M5   = 10'b0000100000,
      S_M6   = 10'b0001000000,
      S_M7   = 10'b0010000000,
      S_M8   = 10'b0100000000,
      S_FILT = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // output register can take a word this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in    = state_ff;
      cmd.load    = 1'b0;
      cmd.mul_sel = MUL_ERR_TS;
      cmd.wb_sel  = WB_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_M1;
            end
         end
         S_M1: begin
            cmd.mul_sel = MUL_ERR_TS;
            state_in    = S_M2;
         end
         S_M2: begin
            cmd.mul_sel = MUL_DERR_ITS;
            cmd.wb_sel  = WB_INTEG;
            state_in    = S_M3;
         end
         S_M3: begin
            cmd.mul_sel = MUL_PG_ERR;
            cmd.wb_sel  = WB_DERIV;
            state_in    = S_M4;
         end
         S_M4: begin
            cmd.mul_sel = MUL_IG_HI;
            cmd.wb_sel  = WB_PROP;
            state_in    = S_M5;
         end
         S_M5: begin
            cmd.mul_sel = MUL_IG_LO;
            cmd.wb_sel  = WB_HOLD;
            state_in    = S_M6;
         end
         S_M6: begin
            cmd.mul_sel = MUL_DG_HI;
            cmd.wb_sel  = WB_INTEG_TERM;
            state_in    = S_M7;
         end
         S_M7: begin
            cmd.mul_sel = MUL_DG_LO;
            cmd.wb_sel  = WB_HOLD;
            state_in    = S_M8;
         end
         S_M8: begin
            cmd.wb_sel = WB_DERIV_TERM;
            state_in   = S_FILT;
         end
         S_FILT: begin
            if (out_free) begin
               cmd.wb_sel = WB_FILTER;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (state_ff == S_FILT && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: design/pid_with_safety_filter_core.sv
// ----------------------------------------------------------------------------
// pid_with_safety_filter_core: PID controller with safety filter
// One input word is one control tick; one result word comes back per tick.
// ----------------------------------------------------------------------------
// Each tick forms error = target - measured, a candidate integral (saturated
// to 48 bits), a derivative scaled by the configured 1/dt, and the PID sum,
// then filters it: missed deadline or 80 C stops (drive 0), 70 C derates to
// 0..0.75, 4 A clips to 0..0.5, else 0..1. The integral is kept only when
// the command was not clipped. Once accepted, a word runs through the
// sequencing states S_M1 to S_M8, which issue seven products on the single
// shared 34x34 multiplier (the integral and derivative terms are each split
// into two halves), then through the filter state S_FILT. A new word is
// accepted only in the idle state after the filter. The result sits in an
// output register, so the next word is taken and computed while it waits;
// only the filter step waits for it to drain. Registers are to be written
// through csr_* only while no tick is in flight, unchecked by the core.
// ----------------------------------------------------------------------------
module pid_with_safety_filter_core
   import pwsf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // input words
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [DATA_W-1:0] req_target,
   input  logic signed [DATA_W-1:0] req_measured,
   input  logic signed [SENS_W-1:0] req_motor_current,
   input  logic signed [SENS_W-1:0] req_temperature,
   input  logic                     req_deadline_miss,
   // result words
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [DRIVE_W-1:0]       rsp_drive,
   output logic                     rsp_clipped,
   output logic [CAUSE_W-1:0]       rsp_cause,
   // register write port
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_wdata
);

   dp_cmd_type cmd;

   // sequencer: handshakes and step commands
   pwsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // arithmetic, loop state, registers and result word
   pwsf_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_target        (req_target),
      .req_measured      (req_measured),
      .req_motor_current (req_motor_current),
      .req_temperature   (req_temperature),
      .req_deadline_miss (req_deadline_miss),
      .cmd               (cmd),
      .rsp_drive         (rsp_drive),
      .rsp_clipped       (rsp_clipped),
      .rsp_cause         (rsp_cause)
   );

endmodule

// File: design/pwsf_checker.sv
// ----------------------------------------------------------------------------
// pwsf_checker: port-level checks
// Watches the result channel of the core; attached by bind.
// ----------------------------------------------------------------------------
module pwsf_checker
   import pwsf_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [DRIVE_W-1:0]       rsp_drive,
   input logic                     rsp_clipped,
   input logic [CAUSE_W-1:0]       rsp_cause
);

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive) &&
         $stable(rsp_clipped) && $stable(rsp_cause))
      else $error("result word changed while stalled");

   // no result right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // stops force a zero command
   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_cause == CAUSE_DEADLINE_STOP ||
                    rsp_cause == CAUSE_THERMAL_STOP) |-> rsp_drive == '0)
      else $error("stop cause with nonzero drive");

   // each cause keeps the command in its band
   a_band: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_drive <= LIM_FULL &&
         (rsp_cause != CAUSE_THERMAL_DERATE || rsp_drive <= LIM_DERATE) &&
         (rsp_cause != CAUSE_CURRENT_CLIP || rsp_drive <= LIM_CURRENT))
      else $error("drive outside the band of its cause");

   // an allowed command strictly inside its band was not clipped
   a_unclipped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cause == CAUSE_ALLOWED && rsp_drive != '0 &&
         rsp_drive != LIM_FULL |-> !rsp_clipped)
      else $error("interior command flagged as clipped");

endmodule

bind pid_with_safety_filter_core pwsf_checker u_pwsf_checker (.*);

// File: tb/tb_pid_with_safety_filter_core.sv
// ----------------------------------------------------------------------------
// tb_pid_with_safety_filter_core: self-checking bench for the PID core
// Drives control ticks through the req_ channel and checks each rsp_ word
// against a cycle-free predictor of the PID sum and safety filter. Several
// register settings are covered, with random idling on both sides and one
// long output stall that backs the core up.
// ----------------------------------------------------------------------------
module tb_pid_with_safety_filter_core;
   import pwsf_pkg::*;

   localparam int HOLD_CYCLES  = 300;   // long receiver stall
   localparam int DRAIN_CYCLES = 20;    // pad after the last result
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd5;   // no register here
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic signed [127:0] INTEG_HI = 128'sh7FFF_FFFF_FFFF;
   localparam logic signed [127:0] INTEG_LO = -INTEG_HI - 1;

   // one control tick as presented on req_*
   typedef struct {
      logic signed [DATA_W-1:0] target;
      logic signed [DATA_W-1:0] measured;
      logic signed [SENS_W-1:0] current;
      logic signed [SENS_W-1:0] temp;
      logic                     miss;
   } tick_type;

   // one result word as expected on rsp_*
   typedef struct {
      logic [DRIVE_W-1:0] drive;
      logic               clipped;
      cause_type          cause;
   } drive_result_type;

   // -------------------------------------------------------------------------
   // Predictor and result store
   // -------------------------------------------------------------------------
   class pid_drive_checker;
      int errors;
      logic signed [DATA_W-1:0] prop_gain, integ_gain, deriv_gain;
      logic [DATA_W-1:0]        time_step, inv_step;
      logic signed [INTEG_W-1:0] integ_acc;
      logic signed [ERR_W-1:0]   prev_error;
      drive_result_type expected_drives[$];

      function new();
         errors     = 0;
         prop_gain  = PROP_GAIN_RST;
         integ_gain = INTEG_GAIN_RST;
         deriv_gain = DERIV_GAIN_RST;
         time_step  = TIME_STEP_RST;
         inv_step   = INV_STEP_RST;
         integ_acc  = '0;
         prev_error = '0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
         unique case (idx)
            CSR_PROP_GAIN:  prop_gain  = val;
            CSR_INTEG_GAIN: integ_gain = val;
            CSR_DERIV_GAIN: deriv_gain = val;
            CSR_TIME_STEP:  time_step  = val;
            CSR_INV_STEP:   inv_step   = val;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_drives.size();
      endfunction

      // exact products in 128 bits, >>> gives the floor
      function void predict_tick(tick_type t);
         logic signed [127:0] err, meas, isum, derr, deriv, cand, lim, drv;
         logic signed [127:0] pg, ig, dg, ts, its;
         drive_result_type r;
         err  = t.target;
         meas = t.measured;
         err  = err - meas;
         ts   = {96'd0, time_step};
         its  = {96'd0, inv_step};
         pg   = prop_gain;
         ig   = integ_gain;
         dg   = deriv_gain;

         isum = integ_acc;
         isum = isum + ((err * ts) >>> 16);
         if (isum > INTEG_HI) isum = INTEG_HI;
         if (isum < INTEG_LO) isum = INTEG_LO;

         derr  = prev_error;
         derr  = err - derr;
         deriv = (derr * its) >>> 16;

         cand = ((pg * err) >>> 24) + ((ig * isum) >>> 40) + ((dg * deriv) >>> 24);

         // priority filter; stops are a clamp to 0..0
         if (t.miss) begin
            r.cause = CAUSE_DEADLINE_STOP;
            lim = LIM_STOP;
         end else if (t.temp >= TEMP_STOP) begin
            r.cause = CAUSE_THERMAL_STOP;
            lim = LIM_STOP;
         end else if (t.temp >= TEMP_DERATE) begin
            r.cause = CAUSE_THERMAL_DERATE;
            lim = LIM_DERATE;
         end else if (t.current >= CURRENT_LIMIT) begin
            r.cause = CAUSE_CURRENT_CLIP;
            lim = LIM_CURRENT;
         end else begin
            r.cause = CAUSE_ALLOWED;
            lim = LIM_FULL;
         end

         if (cand < 0) drv = 0;
         else if (cand > lim) drv = lim;
         else drv = cand;

         r.drive   = drv[DRIVE_W-1:0];
         r.clipped = (drv != cand);
         if (!r.clipped) integ_acc = isum[INTEG_W-1:0];
         prev_error = err[ERR_W-1:0];
         expected_drives.push_back(r);
      endfunction

      task report(string what);
         $display("MISMATCH at %0t: %s", $time, what);
         errors++;
      endtask

      task check_drive(logic [DRIVE_W-1:0] drive, logic clipped,
                       logic [CAUSE_W-1:0] cause);
         drive_result_type want;
         if (expected_drives.size() == 0) begin
            report($sformatf("result word with none pending: drive=%0d clipped=%0d cause=%0d",
                             drive, clipped, cause));
            return;
         end
         want = expected_drives.pop_front();
         if (drive !== want.drive)
            report($sformatf("drive %0d, want %0d", drive, want.drive));
         if (clipped !== want.clipped)
            report($sformatf("clipped %0d, want %0d", clipped, want.clipped));
         if (cause !== want.cause)
            report($sformatf("cause %0d, want %0d", cause, want.cause));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // DUT and its signals; every input starts at a known value
   // -------------------------------------------------------------------------
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [DATA_W-1:0] req_target = '0;
   logic signed [DATA_W-1:0] req_measured = '0;
   logic signed [SENS_W-1:0] req_motor_current = '0;
   logic signed [SENS_W-1:0] req_temperature = '0;
   logic                     req_deadline_miss = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [DRIVE_W-1:0]       rsp_drive;
   logic                     rsp_clipped;
   logic [CAUSE_W-1:0]       rsp_cause;
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [DATA_W-1:0]        csr_wdata = '0;

   pid_with_safety_filter_core dut (.*);

   pid_drive_checker sb;

   // idle odds in percent per cycle, set per phase
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   // long-stall handshake between the stimulus and the receiver process
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   // hard stop in case the core hangs
   initial begin
      #1_000_000;
      $display("pid_with_safety_filter_core verification failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Receiver: ready changes on the falling edge, words taken on the rising
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         // start a long stall, counted down here
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES;
         rsp_ready   <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_drive(rsp_drive, rsp_clipped, rsp_cause);
   end

   // -------------------------------------------------------------------------
   // Sender side
   // -------------------------------------------------------------------------

   // offer one word, with random idle cycles ahead of it, and wait for accept
   task automatic send_tick(input tick_type t);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_target        <= t.target;
      req_measured      <= t.measured;
      req_motor_current <= t.current;
      req_temperature   <= t.temp;
      req_deadline_miss <= t.miss;
      do @(posedge clock); while (!(req_valid && req_ready));
      sb.predict_tick(t);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // all results back, then let the core settle
   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // register write; only called with nothing in flight
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   function automatic tick_type mk(input logic signed [DATA_W-1:0] tg, ms,
                                   input logic signed [SENS_W-1:0] cur, tp,
                                   input logic miss);
      tick_type t;
      t.target   = tg;
      t.measured = ms;
      t.current  = cur;
      t.temp     = tp;
      t.miss     = miss;
      return t;
   endfunction

   // mostly plausible control ticks, some full-range noise; sensors often sit
   // right on a safety threshold
   function automatic tick_type random_tick();
      tick_type t;
      int span;
      int v;
      case ($urandom_range(3))
         0:       span = 1 << 14;
         1:       span = 1 << 20;
         2:       span = 1 << 25;
         default: span = 0;
      endcase
      if (span == 0) begin
         t.target   = $urandom;
         t.measured = $urandom;
      end else begin
         t.target   = int'($urandom_range(0, 2 * span)) - span;
         t.measured = t.target + (int'($urandom_range(0, span)) - span / 2);
      end

      case ($urandom_range(4))
         0: begin
            v = int'(CURRENT_LIMIT) + int'($urandom_range(0, 4)) - 2;
            t.current = v[SENS_W-1:0];
         end
         1:       t.current = SENS_W'($urandom_range(0, 65535));
         default: t.current = SENS_W'($urandom_range(0, 2047));
      endcase

      case ($urandom_range(5))
         0: begin
            v = int'(TEMP_STOP) + int'($urandom_range(0, 4)) - 2;
            t.temp = v[SENS_W-1:0];
         end
         1: begin
            v = int'(TEMP_DERATE) + int'($urandom_range(0, 4)) - 2;
            t.temp = v[SENS_W-1:0];
         end
         2:       t.temp = SENS_W'($urandom_range(0, 65535));
         default: t.temp = SENS_W'($urandom_range(0, 17000));
      endcase

      t.miss = ($urandom_range(9) == 0);
      return t;
   endfunction

   task automatic run_random(input int count);
      for (int i = 0; i < count; i++) send_tick(random_tick());
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Phase 1: reset gains, sender idles rarely, receiver often
      send_idle_pct = 13;
      recv_idle_pct = 63;

      // directed: zero error, field extremes, every filter cause and the
      // threshold edges
      send_tick(mk(32'sd0, 32'sd0, 16'sd0, 16'sd0, 1'b0));
      send_tick(mk(32'sh7FFF_FFFF, 32'sh8000_0000, 16'sd0, 16'sd0, 1'b0));
      send_tick(mk(32'sh8000_0000, 32'sh7FFF_FFFF, 16'sd0, 16'sd0, 1'b0));
      send_tick(mk(32'sd0, 32'sd0, 16'sd0, 16'sd0, 1'b0));
      send_tick(mk(32'sd6553600, 32'sd0, 16'sd0, 16'sd0, 1'b0));
      send_tick(mk(32'sd6553600, 32'sd0, 16'sd0, 16'sd0, 1'b1));
      send_tick(mk(32'sd6553600, 32'sd0, 16'sd0, TEMP_STOP, 1'b0));
      send_tick(mk(32'sd6553600, 32'sd0, 16'sd0, TEMP_STOP - 16'sd1, 1'b0));
      send_tick(mk(32'sd6553600, 32'sd0, 16'sd0, TEMP_DERATE, 1'b0));
      send_tick(mk(32'sd6553600, 32'sd0, CURRENT_LIMIT, TEMP_DERATE - 16'sd1, 1'b0));
      send_tick(mk(32'sd6553600, 32'sd0, CURRENT_LIMIT - 16'sd1, 16'sd0, 1'b0));
      send_tick(mk(32'sd655360, 32'sd0, 16'sh7FFF, 16'sh8000, 1'b0));
      send_tick(mk(32'sd655360, 32'sd0, 16'sh8000, 16'sh7FFF, 1'b0));
      send_tick(mk(32'sd1048576, 32'sd0, 16'sd0, TEMP_DERATE, 1'b0));
      send_tick(mk(32'sd1048576, 32'sd0, CURRENT_LIMIT, 16'sd0, 1'b0));
      send_tick(mk(32'sd0, 32'sd0, CURRENT_LIMIT, 16'sd0, 1'b1));
      send_tick(mk(32'sh8000_0000, 32'sh8000_0000, 16'sd0, 16'sd0, 1'b0));
      send_tick(mk(-32'sd655360, 32'sd0, 16'sd0, 16'sd0, 1'b0));
      run_random(180);
      stop_sending();
      wait_drained();

      // Phase 2a: gains zero, full dt, zero 1/dt; every candidate is zero so
      // the integral always commits and runs into both 48-bit bounds.
      // Zero candidate under a stop is not a clip.
      send_idle_pct = 63;
      recv_idle_pct = 13;
      write_reg(CSR_PROP_GAIN, 32'h0000_0000);
      write_reg(CSR_INTEG_GAIN, 32'h0000_0000);
      write_reg(CSR_DERIV_GAIN, 32'h0000_0000);
      write_reg(CSR_TIME_STEP, 32'hFFFF_FFFF);
      write_reg(CSR_INV_STEP, 32'h0000_0000);
      send_tick(mk(32'sh7FFF_FFFF, 32'sh8000_0000, 16'sd0, 16'sd0, 1'b0));
      send_tick(mk(32'sh7FFF_FFFF, 32'sh8000_0000, 16'sd0, 16'sd0, 1'b0));
      send_tick(mk(32'sh7FFF_FFFF, 32'sh8000_0000, 16'sd0, TEMP_STOP, 1'b0));
      send_tick(mk(32'sh8000_0000, 32'sh7FFF_FFFF, 16'sd0, 16'sd0, 1'b1));
      send_tick(mk(32'sh8000_0000, 32'sh7FFF_FFFF, 16'sd0, 16'sd0, 1'b0));
      send_tick(mk(32'sh8000_0000, 32'sh7FFF_FFFF, 16'sd0, 16'sd0, 1'b0));
      stop_sending();
      wait_drained();

      // Phase 2b: extreme gains and the saturated integral from above; the
      // integral gain now brings the clamped value into the sum
      write_reg(CSR_INTEG_GAIN, 32'h8000_0000);
      send_tick(mk(32'sd0, 32'sd0, 16'sd0, 16'sd0, 1'b0));
      stop_sending();
      wait_drained();
      write_reg(CSR_PROP_GAIN, 32'h7FFF_FFFF);
      write_reg(CSR_DERIV_GAIN, 32'h7FFF_FFFF);
      write_reg(CSR_INV_STEP, 32'hFFFF_FFFF);
      run_random(180);
      stop_sending();
      wait_drained();

      // Phase 3a: moderate random gains, no idling, one long output stall
      // while the sender keeps offering words
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(CSR_PROP_GAIN, $urandom_range(0, 1 << 25) - (1 << 24));
      write_reg(CSR_INTEG_GAIN, $urandom_range(0, 1 << 25) - (1 << 24));
      write_reg(CSR_DERIV_GAIN, $urandom_range(0, 1 << 20) - (1 << 19));
      write_reg(CSR_TIME_STEP, $urandom);
      write_reg(CSR_INV_STEP, $urandom_range(0, 1 << 26));
      write_reg(CSR_SPARE_LO, $urandom);   // no register behind these
      write_reg(CSR_SPARE_HI, 32'hFFFF_FFFF);
      run_random(20);
      hold_requests = hold_requests + 1;
      run_random(80);
      stop_sending();
      wait_drained();

      // Phase 3b: opposite extremes, zero dt freezes the integral
      write_reg(CSR_PROP_GAIN, 32'h8000_0000);
      write_reg(CSR_INTEG_GAIN, 32'h7FFF_FFFF);
      write_reg(CSR_DERIV_GAIN, 32'h8000_0000);
      write_reg(CSR_TIME_STEP, 32'h0000_0000);
      write_reg(CSR_INV_STEP, 32'h0001_0000);
      run_random(90);
      stop_sending();
      wait_drained();

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("pid_with_safety_filter_core verification clean");
      end else begin
         $display("pid_with_safety_filter_core verification failed");
      end
      $finish;
   end

endmodule
